// ===== sv/sha_pkg.sv =====
`default_nettype none

package sha_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0][31:0] hash_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [63:0] digest_part;
    logic [1:0]  part_index;
    logic        last_part;
  } out_t;

  typedef struct packed {
    logic       byte_en;
    logic [7:0] byte_val;
    logic       start;
    logic       chain_clr;
  } core_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMP,
    ST_PAD,
    ST_LEN,
    ST_OUT
  } state_e;

  localparam logic [7:0] PadByte   = 8'h80;
  localparam logic [5:0] LenPos    = 6'd56;
  localparam logic [5:0] LastByte  = 6'd63;
  localparam logic [5:0] LastRound = 6'd63;

  // word 0 sits in the low slot
  localparam hash_t InitHash = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t sig0(input word_t x);
    sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t sig1(input word_t x);
    sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(input word_t x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

`default_nettype wire

// ===== sv/sha_core.sv =====
`default_nettype none

module sha_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sha_pkg::core_ctrl_t ctrl_i,
  output logic                busy_o,
  output sha_pkg::hash_t      chain_o
);
  import sha_pkg::*;

  // block bytes shift in at the bottom; word 0 ends up in the top 32 bits,
  // and during rounds the same register is the schedule window
  logic [511:0] blk_q, blk_d;
  hash_t        chain_q, chain_d;
  hash_t        vars_q, vars_d;
  logic [5:0]   round_q, round_d;
  logic         run_q, run_d;
  logic         fin_q, fin_d;

  word_t w0, w1, w9, w14, w_next;
  word_t t1, t2, ch, maj;

  always_comb begin
    w0     = blk_q[511 -: 32];
    w1     = blk_q[479 -: 32];
    w9     = blk_q[223 -: 32];
    w14    = blk_q[63 -: 32];
    w_next = sig1(w14) + w9 + sig0(w1) + w0;

    ch  = (vars_q[4] & vars_q[5]) ^ (~vars_q[4] & vars_q[6]);
    maj = (vars_q[0] & vars_q[1]) ^ (vars_q[0] & vars_q[2]) ^ (vars_q[1] & vars_q[2]);
    t1  = vars_q[7] + bsig1(vars_q[4]) + ch + RoundK[round_q] + w0;
    t2  = bsig0(vars_q[0]) + maj;
  end

  always_comb begin
    blk_d   = blk_q;
    chain_d = chain_q;
    vars_d  = vars_q;
    round_d = round_q;
    run_d   = run_q;
    fin_d   = 1'b0;

    if (ctrl_i.byte_en) begin
      blk_d = {blk_q[503:0], ctrl_i.byte_val};
    end

    if (ctrl_i.start) begin
      vars_d  = chain_q;
      round_d = '0;
      run_d   = 1'b1;
    end else if (run_q) begin
      blk_d     = {blk_q[479:0], w_next};
      vars_d[7] = vars_q[6];
      vars_d[6] = vars_q[5];
      vars_d[5] = vars_q[4];
      vars_d[4] = vars_q[3] + t1;
      vars_d[3] = vars_q[2];
      vars_d[2] = vars_q[1];
      vars_d[1] = vars_q[0];
      vars_d[0] = t1 + t2;
      round_d   = round_q + 6'd1;
      if (round_q == LastRound) begin
        run_d = 1'b0;
        fin_d = 1'b1;
      end
    end

    if (fin_q) begin
      for (int i = 0; i < 8; i++) begin
        chain_d[i] = chain_q[i] + vars_q[i];
      end
    end

    if (ctrl_i.chain_clr) begin
      chain_d = InitHash;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= InitHash;
      round_q <= '0;
      run_q   <= 1'b0;
      fin_q   <= 1'b0;
    end else begin
      chain_q <= chain_d;
      round_q <= round_d;
      run_q   <= run_d;
      fin_q   <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q  <= blk_d;
    vars_q <= vars_d;
  end

  assign busy_o  = run_q | fin_q;
  assign chain_o = chain_q;

endmodule

`default_nettype wire

// ===== sv/sha256_stream_hash.sv =====
`default_nettype none

// channel   direction  handshake              payload
// in        input      in_valid_i/in_stall_o   in_data_i  (byte, has_byte, last)
// out       output     out_valid_o/out_stall_i out_data_o (digest part, index, last)
//
// a message byte is taken while idle; a byte that completes a 64-byte block
// holds the input off through 64 rounds of the shared round unit, one chain
// update and the hand-back; at message end padding is fed one byte per cycle
// into the same round unit, pausing while a full block compresses (up to 72
// bytes, one or two block compressions), then four parts are sent
// reset is asynchronous and active low and restores the initial hash values
// a stalled output holds its part; input is taken again while the last part waits

module sha256_stream_hash (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  sha_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output sha_pkg::out_t out_data_o
);
  import sha_pkg::*;

  state_e      state_q, state_d;
  state_e      ret_q, ret_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] bits_q, bits_d;
  logic        pad_first_q, pad_first_d;
  logic [1:0]  part_q, part_d;
  logic        out_valid_q, out_valid_d;
  out_t        out_q;
  logic        load_out;

  core_ctrl_t  core_ctrl;
  logic        core_busy;
  hash_t       chain;

  sha_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (core_ctrl),
    .busy_o  (core_busy),
    .chain_o (chain)
  );

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    cnt_d       = cnt_q;
    bits_d      = bits_q;
    pad_first_d = pad_first_q;
    part_d      = part_q;
    core_ctrl   = '0;
    in_stall_o  = 1'b1;
    load_out    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          pad_first_d = 1'b1;
          if (in_data_i.has_byte) begin
            core_ctrl.byte_en  = 1'b1;
            core_ctrl.byte_val = in_data_i.data_byte;
            cnt_d  = cnt_q + 6'd1;
            bits_d = bits_q + 64'd8;
            if (cnt_q == LastByte) begin
              core_ctrl.start = 1'b1;
              state_d = ST_COMP;
              ret_d   = in_data_i.last ? ST_PAD : ST_IDLE;
            end else if (in_data_i.last) begin
              state_d = ST_PAD;
            end
          end else if (in_data_i.last) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_COMP: begin
        if (!core_busy) begin
          state_d = ret_q;
        end
      end
      ST_PAD: begin
        if (pad_first_q || cnt_q != LenPos) begin
          core_ctrl.byte_en  = 1'b1;
          core_ctrl.byte_val = pad_first_q ? PadByte : 8'h00;
          pad_first_d = 1'b0;
          cnt_d = cnt_q + 6'd1;
          if (cnt_q == LastByte) begin
            core_ctrl.start = 1'b1;
            state_d = ST_COMP;
            ret_d   = ST_PAD;
          end
        end else begin
          state_d = ST_LEN;
        end
      end
      ST_LEN: begin
        // length goes out msb first; the count shifts to zero on the way
        core_ctrl.byte_en  = 1'b1;
        core_ctrl.byte_val = bits_q[63:56];
        bits_d = {bits_q[55:0], 8'h00};
        cnt_d  = cnt_q + 6'd1;
        if (cnt_q == LastByte) begin
          core_ctrl.start = 1'b1;
          state_d = ST_COMP;
          ret_d   = ST_OUT;
          part_d  = '0;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          part_d   = part_q + 2'd1;
          if (part_q == 2'd3) begin
            core_ctrl.chain_clr = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = load_out | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= ST_IDLE;
      cnt_q       <= '0;
      bits_q      <= '0;
      pad_first_q <= 1'b0;
      part_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      cnt_q       <= cnt_d;
      bits_q      <= bits_d;
      pad_first_q <= pad_first_d;
      part_q      <= part_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.digest_part <= {chain[{part_q, 1'b0}], chain[{part_q, 1'b1}]};
      out_q.part_index  <= part_q;
      out_q.last_part   <= (part_q == 2'd3);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
